// ===== rtl/core/foc_vm_pkg.sv =====
// ----------------------------------------------------------------------------
// FOC voltage modulator package
// Shared field widths, fixed-point formats and transaction payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package foc_vm_pkg;

   // Angle is a turn fraction; sine values are Q(SINE_FRAC_BITS).
   localparam int ANGLE_BITS     = 16;
   localparam int SINE_FRAC_BITS = 15;
   localparam int SINE_W         = SINE_FRAC_BITS + 2;
   localparam int SINE_LAT       = 7;

   localparam int CMD_W    = 16;
   localparam int ANG_IN_W = 16;
   localparam int VOLT_W   = 15;
   localparam int PERIOD_W = 16;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_SUPPLY_VOLTAGE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLTAGE_LIMIT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_PERIOD     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_ANGLE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CLAMP_COMMAND  = 3'd4;

   // Doubled command, Q7.9.
   localparam int UQ2_W = CMD_W + 1;
   // Park products and the Q16 sqrt(3) scaled product.
   localparam int PROD_W = UQ2_W + SINE_W + 1;
   localparam int PH_W   = SINE_FRAC_BITS + 40;
   localparam int SQRT3_Q16 = 113512;

   // Duty divider: dividend is phase voltage times period.
   localparam int DIV_N_W     = VOLT_W + PERIOD_W;
   localparam int DIV_Q_W     = PERIOD_W;
   localparam int DIV_STEPS   = 2;
   localparam int DIV_STAGES  = DIV_Q_W / DIV_STEPS;

   typedef struct packed {
      logic signed [CMD_W-1:0] uq_command;
      logic [ANG_IN_W-1:0]     electric_angle;
   } req_payload_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] width_a;
      logic [PERIOD_W-1:0] width_b;
      logic [PERIOD_W-1:0] width_c;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ===== rtl/core/foc_vm_sine.sv =====
// ----------------------------------------------------------------------------
// FOC voltage modulator sine pipeline
// Quadrant fold and 9th-order odd polynomial, at most one multiply per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module foc_vm_sine (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      enable,
   input  wire logic                                      in_valid,
   input  wire logic [foc_vm_pkg::ANGLE_BITS-1:0]         angle,
   output logic                                           out_valid,
   output logic signed [foc_vm_pkg::SINE_W-1:0]           sine
);

   localparam int AB = foc_vm_pkg::ANGLE_BITS;
   localparam int F  = foc_vm_pkg::SINE_FRAC_BITS;
   localparam int LAT = foc_vm_pkg::SINE_LAT;

   localparam logic [31:0] COEF1 = 32'd1686629713;
   localparam logic [31:0] COEF3 = 32'd693598668;
   localparam logic [31:0] COEF5 = 32'd85569304;
   localparam logic [31:0] COEF7 = 32'd5026995;
   localparam logic [31:0] COEF9 = 32'd172272;

   // One Horner step: coef - (x2 * p) >> 30, all Q30.
   function automatic logic [31:0] horner(input logic [30:0] x2, input logic [31:0] p,
                                          input logic [31:0] coef);
      logic [63:0] m;
      m = {33'b0, x2} * {32'b0, p};
      return coef - m[61:30];
   endfunction

   logic [LAT-1:0] valid_ff, valid_in;
   logic           neg_ff [LAT-1];
   logic [30:0]    x_ff   [LAT-1];
   logic [30:0]    x2_ff  [LAT-3];
   logic [31:0]    p_ff   [4];
   logic signed [foc_vm_pkg::SINE_W-1:0] sine_ff, sine_in;

   logic [1:0]    quad;
   logic [AB-2:0] r;
   logic [30:0]   x_in;
   logic [63:0]   xx;
   logic [63:0]   xp;
   logic [39:0]   mag;

   always_comb begin
      quad = angle[AB-1:AB-2];
      r    = {1'b0, angle[AB-3:0]};
      if (quad[0]) begin
         r = (AB-1)'(1 << (AB-2)) - r;
      end
      x_in = 31'(r) << (32 - AB);
   end

   assign xx = {33'b0, x_ff[0]} * {33'b0, x_ff[0]};

   always_comb begin
      xp  = {33'b0, x_ff[LAT-2]} * {32'b0, p_ff[3]};
      mag = (40'(xp >> 30) + (40'(1) << (29 - F))) >> (30 - F);
      if (mag > (40'(1) << F)) begin
         mag = 40'(1) << F;
      end
      if (neg_ff[LAT-2]) begin
         sine_in = -$signed(foc_vm_pkg::SINE_W'(mag));
      end else begin
         sine_in = $signed(foc_vm_pkg::SINE_W'(mag));
      end
   end

   assign valid_in = {valid_ff[LAT-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         neg_ff[0] <= quad[1];
         x_ff[0]   <= x_in;
         for (int i = 1; i < LAT-1; i++) begin
            neg_ff[i] <= neg_ff[i-1];
         end
         for (int i = 1; i < LAT-1; i++) begin
            x_ff[i] <= x_ff[i-1];
         end
         x2_ff[0] <= xx[60:30];
         for (int i = 1; i < LAT-3; i++) begin
            x2_ff[i] <= x2_ff[i-1];
         end
         p_ff[0] <= horner(x2_ff[0], COEF9, COEF7);
         p_ff[1] <= horner(x2_ff[1], p_ff[0], COEF5);
         p_ff[2] <= horner(x2_ff[2], p_ff[1], COEF3);
         p_ff[3] <= horner(x2_ff[3], p_ff[2], COEF1);
         sine_ff <= sine_in;
      end
   end

   assign out_valid = valid_ff[LAT-1];
   assign sine      = sine_ff;

endmodule

`default_nettype wire

// ===== rtl/core/foc_vm_divider.sv =====
// ----------------------------------------------------------------------------
// FOC voltage modulator duty divider
// Pipelined restoring divider, two quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module foc_vm_divider (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               enable,
   input  wire logic                               in_valid,
   input  wire logic [foc_vm_pkg::DIV_N_W-1:0]     dividend,
   input  wire logic [foc_vm_pkg::VOLT_W-1:0]      divisor,
   output logic                                    out_valid,
   output logic [foc_vm_pkg::DIV_Q_W-1:0]          quotient
);

   localparam int NW = foc_vm_pkg::DIV_N_W;
   localparam int QW = foc_vm_pkg::DIV_Q_W;
   localparam int NS = foc_vm_pkg::DIV_STAGES;
   localparam int SP = foc_vm_pkg::DIV_STEPS;

   logic [NW-1:0] rem_ff [NS];
   logic [QW-1:0] quo_ff [NS];
   logic [NS-1:0] valid_ff;

   for (genvar k = 0; k < NS; k++) begin : g_stage
      logic [NW-1:0] rem_src, rem_in;
      logic [QW-1:0] quo_src, quo_in;
      logic          valid_src;

      if (k == 0) begin : g_first
         assign rem_src   = dividend;
         assign quo_src   = '0;
         assign valid_src = in_valid;
      end else begin : g_next
         assign rem_src   = rem_ff[k-1];
         assign quo_src   = quo_ff[k-1];
         assign valid_src = valid_ff[k-1];
      end

      always_comb begin
         logic [NW-1:0] d;
         rem_in = rem_src;
         quo_in = quo_src;
         for (int j = 0; j < SP; j++) begin
            d = NW'(divisor) << (QW - 1 - SP*k - j);
            if (rem_in >= d) begin
               rem_in = rem_in - d;
               quo_in[QW - 1 - SP*k - j] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k] <= rem_in;
            quo_ff[k] <= quo_in;
         end
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign quotient  = quo_ff[NS-1];

endmodule

`default_nettype wire

// ===== rtl/core/foc_voltage_modulator.sv =====
// ----------------------------------------------------------------------------
// FOC voltage modulator
// Inverse Park and Clarke transform with sine PWM compare width output.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid/req_ready/req_payload) takes a signed
//   Q7.8 quadrature command and a 16-bit electrical angle. Each transaction
//   yields one response transaction on rsp_valid/rsp_ready/rsp_payload with
//   the three phase compare widths, in order.
//   From acceptance to rsp_valid a transaction passes one angle stage,
//   seven sine stages, four Park/Clarke/scaling stages, eight divider
//   stages and the output register. Throughput is one transaction per
//   cycle unless the receiver stalls, set by the fully pipelined sine
//   polynomial and the restoring divider at two quotient bits per stage.
//   When the receiver stalls, the whole pipeline holds in place and
//   req_ready drops; nothing is lost or repeated. req_ready is high
//   whenever the output register is empty or being emptied.
//   Reset clears all valid bits and loads the register defaults: supply
//   and limit 12 V, period 1000, zero angle 0, command clamp on.
//   The user writes registers via csr_write_enable/csr_index/csr_write_data
//   only while no transaction is in flight; the block does not check this.
// ----------------------------------------------------------------------------
`default_nettype none

module foc_voltage_modulator (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire foc_vm_pkg::req_payload_type           req_payload,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output foc_vm_pkg::rsp_payload_type                rsp_payload,
   input  wire logic                                  csr_write_enable,
   input  wire logic [foc_vm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [foc_vm_pkg::CSR_W-1:0]          csr_write_data
);

   localparam int AB      = foc_vm_pkg::ANGLE_BITS;
   localparam int F       = foc_vm_pkg::SINE_FRAC_BITS;
   localparam int VW      = foc_vm_pkg::VOLT_W;
   localparam int PW      = foc_vm_pkg::PROD_W;
   localparam int HW      = foc_vm_pkg::PH_W;
   localparam int UW      = foc_vm_pkg::UQ2_W;
   localparam int SINE_LAT = foc_vm_pkg::SINE_LAT;

   // ---------------- configuration registers ----------------
   logic [VW-1:0]                     supply_ff;
   logic [VW-1:0]                     limit_ff;
   logic [foc_vm_pkg::PERIOD_W-1:0]   period_ff;
   logic [foc_vm_pkg::ANG_IN_W-1:0]   zero_ff;
   logic                              clamp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         supply_ff <= VW'(3072);
         limit_ff  <= VW'(3072);
         period_ff <= 16'd1000;
         zero_ff   <= '0;
         clamp_ff  <= 1'b1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            foc_vm_pkg::CSR_SUPPLY_VOLTAGE: supply_ff <= csr_write_data[VW-1:0];
            foc_vm_pkg::CSR_VOLTAGE_LIMIT:  limit_ff  <= csr_write_data[VW-1:0];
            foc_vm_pkg::CSR_PWM_PERIOD:     period_ff <= csr_write_data;
            foc_vm_pkg::CSR_ZERO_ANGLE:     zero_ff   <= csr_write_data;
            foc_vm_pkg::CSR_CLAMP_COMMAND:  clamp_ff  <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // The whole pipeline advances together; it holds only while a finished
   // transaction waits in the output register.
   logic stage_en;
   logic rsp_valid_ff;
   assign stage_en  = !rsp_valid_ff || rsp_ready;
   assign req_ready = stage_en;

   // ---------------- stage 1: angle offset and command clamp ----------------
   logic [foc_vm_pkg::ANG_IN_W-1:0] theta;
   logic [39:0]                     theta_wide;
   logic [AB-1:0]                   ang_s_in, ang_c_in, ang_s_ff, ang_c_ff;
   logic signed [UW-1:0]            uq2_in, sup_s;
   logic                            v1_ff;
   logic signed [UW-1:0]            uq2_ff [SINE_LAT+1];

   always_comb begin
      theta      = req_payload.electric_angle - zero_ff;
      theta_wide = {theta, 24'b0};
      ang_s_in   = theta_wide[39 -: AB];
      ang_c_in   = ang_s_in + AB'(1 << (AB - 2));
      sup_s      = $signed({2'b0, supply_ff});
      uq2_in     = $signed({req_payload.uq_command, 1'b0});
      if (clamp_ff) begin
         if (uq2_in > sup_s) begin
            uq2_in = sup_s;
         end
         if (uq2_in < -sup_s) begin
            uq2_in = -sup_s;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (stage_en) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         ang_s_ff  <= ang_s_in;
         ang_c_ff  <= ang_c_in;
         uq2_ff[0] <= uq2_in;
         for (int i = 1; i <= SINE_LAT; i++) begin
            uq2_ff[i] <= uq2_ff[i-1];
         end
      end
   end

   // ---------------- sine and cosine pipelines ----------------
   logic                                   sin_valid;
   logic signed [foc_vm_pkg::SINE_W-1:0]   sin_val, cos_val;

   foc_vm_sine u_sin (
      .clock     (clock),
      .reset     (reset),
      .enable    (stage_en),
      .in_valid  (v1_ff),
      .angle     (ang_s_ff),
      .out_valid (sin_valid),
      .sine      (sin_val)
   );

   foc_vm_sine u_cos (
      .clock     (clock),
      .reset     (reset),
      .enable    (stage_en),
      .in_valid  (v1_ff),
      .angle     (ang_c_ff),
      .out_valid (),
      .sine      (cos_val)
   );

   // ---------------- stage A: inverse Park ----------------
   logic                 va_valid_ff, vb_valid_ff, vc_valid_ff, vd_valid_ff;
   logic signed [PW-1:0] alpha_a_ff, beta_a_ff, alpha_b_ff;
   logic signed [HW-1:0] bk_ff;
   logic [VW-1:0]        volt_ff [3];
   logic [foc_vm_pkg::DIV_N_W-1:0] num_ff [3];

   // ---------------- stage C helpers: round to Q7.8 and clamp ----------------
   function automatic logic [VW-1:0] round_clamp(input logic signed [HW-1:0] v,
                                                 input logic [VW-1:0] lim,
                                                 input logic [VW-1:0] sup);
      logic signed [HW-1:0] t;
      t = (v + (HW'(1) <<< (F + 17))) >>> (F + 18);
      if (t < 0) begin
         t = '0;
      end
      if (t > $signed(HW'(lim))) begin
         t = $signed(HW'(lim));
      end
      if (t > $signed(HW'(sup))) begin
         t = $signed(HW'(sup));
      end
      return t[VW-1:0];
   endfunction

   logic signed [HW-1:0] a_ext, bias, ph_a, ph_b, ph_c;

   always_comb begin
      a_ext = HW'(alpha_b_ff);
      bias  = $signed(HW'(supply_ff)) <<< (F + 17);
      ph_a  = (a_ext <<< 17) + bias;
      ph_b  = bk_ff - (a_ext <<< 16) + bias;
      ph_c  = -(a_ext <<< 16) - bk_ff + bias;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_valid_ff <= 1'b0;
         vb_valid_ff <= 1'b0;
         vc_valid_ff <= 1'b0;
         vd_valid_ff <= 1'b0;
      end else if (stage_en) begin
         va_valid_ff <= sin_valid;
         vb_valid_ff <= va_valid_ff;
         vc_valid_ff <= vb_valid_ff;
         vd_valid_ff <= vc_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         alpha_a_ff <= -(PW'(uq2_ff[SINE_LAT]) * PW'(sin_val));
         beta_a_ff  <= PW'(uq2_ff[SINE_LAT]) * PW'(cos_val);
         alpha_b_ff <= alpha_a_ff;
         bk_ff      <= HW'(beta_a_ff) * HW'(foc_vm_pkg::SQRT3_Q16);
         volt_ff[0] <= round_clamp(ph_a, limit_ff, supply_ff);
         volt_ff[1] <= round_clamp(ph_b, limit_ff, supply_ff);
         volt_ff[2] <= round_clamp(ph_c, limit_ff, supply_ff);
         for (int i = 0; i < 3; i++) begin
            num_ff[i] <= foc_vm_pkg::DIV_N_W'(volt_ff[i]) *
                         foc_vm_pkg::DIV_N_W'(period_ff);
         end
      end
   end

   // ---------------- duty dividers ----------------
   logic                           div_valid;
   logic [foc_vm_pkg::DIV_Q_W-1:0] quo [3];

   foc_vm_divider u_div_a (
      .clock (clock), .reset (reset), .enable (stage_en), .in_valid (vd_valid_ff),
      .dividend (num_ff[0]), .divisor (supply_ff), .out_valid (div_valid),
      .quotient (quo[0])
   );

   foc_vm_divider u_div_b (
      .clock (clock), .reset (reset), .enable (stage_en), .in_valid (vd_valid_ff),
      .dividend (num_ff[1]), .divisor (supply_ff), .out_valid (),
      .quotient (quo[1])
   );

   foc_vm_divider u_div_c (
      .clock (clock), .reset (reset), .enable (stage_en), .in_valid (vd_valid_ff),
      .dividend (num_ff[2]), .divisor (supply_ff), .out_valid (),
      .quotient (quo[2])
   );

   // ---------------- output register ----------------
   foc_vm_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic                        sup_zero;

   // A zero supply gives zero widths; the divider output is meaningless then.
   assign sup_zero = (supply_ff == '0);

   always_comb begin
      rsp_payload_in.width_a = sup_zero ? '0 : quo[0];
      rsp_payload_in.width_b = sup_zero ? '0 : quo[1];
      rsp_payload_in.width_c = sup_zero ? '0 : quo[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stage_en) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // ---------------- assertions ----------------
   a_stall_freezes_pipe: assert property (@(posedge clock) disable iff (reset)
      !stage_en |=> $stable(va_valid_ff) && $stable(vd_valid_ff) && $stable(div_valid))
      else $error("pipeline valid bits moved during a stall");

   a_sine_bounded: assert property (@(posedge clock) disable iff (reset)
      sin_valid |-> (sin_val <= $signed(foc_vm_pkg::SINE_W'(1 << F))) &&
                    (cos_val <= $signed(foc_vm_pkg::SINE_W'(1 << F))) &&
                    (sin_val >= -$signed(foc_vm_pkg::SINE_W'(1 << F))))
      else $error("sine pipeline result out of range");

   a_stalled_response_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_payload_ff))
      else $error("stalled response transaction changed");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// FOC voltage modulator testbench
// Drives quadrature commands and angles through the valid/ready request
// channel, predicts the three PWM compare widths with a bit-exact fixed-point
// model of the inverse Park/Clarke path, and checks every response in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

   localparam longint unsigned C1 = 64'd1686629713;
   localparam longint unsigned C3 = 64'd693598668;
   localparam longint unsigned C5 = 64'd85569304;
   localparam longint unsigned C7 = 64'd5026995;
   localparam longint unsigned C9 = 64'd172272;
   localparam int PIPE_LATENCY = 21;
   localparam int IDLE_LIMIT   = 6000;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   foc_vm_pkg::req_payload_type req_payload;
   logic                        rsp_valid;
   logic                        rsp_ready;
   foc_vm_pkg::rsp_payload_type rsp_payload;
   logic                        csr_write_enable;
   logic [foc_vm_pkg::CSR_IDX_W-1:0] csr_index;
   logic [foc_vm_pkg::CSR_W-1:0]     csr_write_data;

   // Shadow copies of the block's registers.
   longint supply_cfg, limit_cfg, period_cfg;
   logic [15:0] zero_cfg;
   logic        clamp_cfg;

   foc_vm_pkg::rsp_payload_type width_queue[$];
   int error_count, sent_count, checked_count, idle_cycles;
   int send_idle_pct, recv_idle_pct, recv_hold;

   foc_voltage_modulator uut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint sine_q15(logic [15:0] theta);
      longint unsigned r, x, x2, p, v;
      r = theta[13:0];
      if (theta[14]) r = 64'd16384 - r;
      x  = r << 16;
      x2 = (x * x) >> 30;
      p  = C7 - ((x2 * C9) >> 30);
      p  = C5 - ((x2 * p) >> 30);
      p  = C3 - ((x2 * p) >> 30);
      p  = C1 - ((x2 * p) >> 30);
      v  = (x * p) >> 30;
      v  = (v + 64'd16384) >> 15;
      if (v > 64'd32768) v = 64'd32768;
      return theta[15] ? -longint'(v) : longint'(v);
   endfunction

   function automatic logic [15:0] duty_width(longint v);
      v = (v + (longint'(1) <<< 32)) >>> 33;
      if (v < 0) v = 0;
      if (v > limit_cfg) v = limit_cfg;
      if (supply_cfg == 0) return 16'd0;
      if (v > supply_cfg) v = supply_cfg;
      return 16'((v * period_cfg) / supply_cfg);
   endfunction

   function automatic foc_vm_pkg::rsp_payload_type predict_widths(
         foc_vm_pkg::req_payload_type cmd);
      foc_vm_pkg::rsp_payload_type w;
      longint uq2, s, c, alpha, beta, bias;
      logic [15:0] theta;
      uq2 = 2 * longint'($signed(cmd.uq_command));
      if (clamp_cfg) begin
         if (uq2 > supply_cfg) uq2 = supply_cfg;
         if (uq2 < -supply_cfg) uq2 = -supply_cfg;
      end
      theta = cmd.electric_angle - zero_cfg;
      s = sine_q15(theta);
      c = sine_q15(theta + 16'd16384);
      alpha = -uq2 * s;
      beta  = uq2 * c;
      bias  = supply_cfg <<< 32;
      w.width_a = duty_width(alpha * 131072 + bias);
      w.width_b = duty_width(beta * foc_vm_pkg::SQRT3_Q16 - alpha * 65536 + bias);
      w.width_c = duty_width(-alpha * 65536 - beta * foc_vm_pkg::SQRT3_Q16 + bias);
      return w;
   endfunction

   task automatic report_mismatch(string field, logic [15:0] want, logic [15:0] got);
      $display("%0t: %s mismatch, expected %0d got %0d", $realtime, field, want, got);
      error_count++;
   endtask

   // Response checker and watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("tb_top NOT OK");
            $finish;
         end
         if (rsp_valid && rsp_ready) begin
            if (width_queue.size() == 0) begin
               $display("%0t: unexpected response transaction", $realtime);
               error_count++;
            end else begin
               foc_vm_pkg::rsp_payload_type want;
               want = width_queue.pop_front();
               checked_count++;
               if (rsp_payload.width_a !== want.width_a)
                  report_mismatch("width_a", want.width_a, rsp_payload.width_a);
               if (rsp_payload.width_b !== want.width_b)
                  report_mismatch("width_b", want.width_b, rsp_payload.width_b);
               if (rsp_payload.width_c !== want.width_c)
                  report_mismatch("width_c", want.width_c, rsp_payload.width_c);
            end
         end
      end
   end

   // Receiver: random stalls, plus an optional long hold-off.
   always @(negedge clock) begin
      if (recv_hold > 0) begin
         recv_hold--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Entered and left at a falling edge.
   task automatic send_command(logic signed [15:0] uq, logic [15:0] angle);
      int gap;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload.uq_command <= uq;
      req_payload.electric_angle <= angle;
      do @(posedge clock); while (!(req_valid && req_ready));
      width_queue.push_back(predict_widths(req_payload));
      sent_count++;
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      wait (width_queue.size() == 0);
      @(negedge clock);
      repeat (PIPE_LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_csr(logic [foc_vm_pkg::CSR_IDX_W-1:0] idx,
                            logic [foc_vm_pkg::CSR_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         foc_vm_pkg::CSR_SUPPLY_VOLTAGE: supply_cfg = data[14:0];
         foc_vm_pkg::CSR_VOLTAGE_LIMIT:  limit_cfg  = data[14:0];
         foc_vm_pkg::CSR_PWM_PERIOD:     period_cfg = data;
         foc_vm_pkg::CSR_ZERO_ANGLE:     zero_cfg   = data;
         foc_vm_pkg::CSR_CLAMP_COMMAND:  clamp_cfg  = data[0];
         default: ;
      endcase
   endtask

   task automatic configure(int sup, int lim, int per, int zero, int clamp);
      drain();
      write_csr(foc_vm_pkg::CSR_SUPPLY_VOLTAGE, 16'(sup));
      write_csr(foc_vm_pkg::CSR_VOLTAGE_LIMIT, 16'(lim));
      write_csr(foc_vm_pkg::CSR_PWM_PERIOD, 16'(per));
      write_csr(foc_vm_pkg::CSR_ZERO_ANGLE, 16'(zero));
      write_csr(foc_vm_pkg::CSR_CLAMP_COMMAND, 16'(clamp));
   endtask

   task automatic test_directed;
      logic [15:0] angles[5];
      angles = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'd65535};
      foreach (angles[i]) begin
         send_command(16'sh7FFF, angles[i]);
         send_command(-16'sh8000, angles[i]);
      end
      send_command(16'sd0, 16'd12345);
      send_command(16'sd1536, 16'd10923);
      send_command(-16'sd1536, 16'd5461);
      // Command passes through unclamped and the angle is offset.
      configure(3072, 3072, 1000, 16'hC000, 0);
      send_command(16'sh7FFF, 16'd0);
      send_command(-16'sh8000, 16'd21845);
      send_command(16'sd2000, 16'hFFFF);
      // Zero supply forces every width to zero.
      configure(0, 32767, 65535, 0, 1);
      send_command(16'sd1000, 16'd100);
      send_command(-16'sd1000, 16'd40000);
      // Limit above supply saturates duty at one.
      configure(1000, 32767, 65535, 0, 0);
      send_command(16'sh7FFF, 16'd1000);
      send_command(-16'sh8000, 16'd30000);
      // Zero limit and zero period.
      configure(32767, 0, 1000, 0, 1);
      send_command(16'sd500, 16'd7000);
      configure(32767, 32767, 0, 0, 1);
      send_command(16'sd500, 16'd7000);
      send_command(16'sh7FFF, 16'd60000);
   endtask

   task automatic test_random_phase(int count, int mode, bit extreme_cfg, bit long_stall);
      int sup, lim, per;
      if (extreme_cfg) begin
         sup = $urandom_range(1) ? 32767 : 1;
         lim = $urandom_range(1) ? 32767 : 0;
         per = $urandom_range(1) ? 65535 : 1;
      end else begin
         sup = $urandom_range(1, 32767);
         lim = $urandom_range(32767);
         per = $urandom_range(1, 65535);
      end
      configure(sup, lim, per, $urandom_range(65535), $urandom_range(1));
      send_idle_pct = (mode == 0) ? 28 : (mode == 1) ? 81 : 0;
      recv_idle_pct = (mode == 0) ? 81 : (mode == 1) ? 28 : 0;
      if (long_stall) recv_hold = 400;
      repeat (count) send_command(16'($urandom), 16'($urandom));
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      supply_cfg = 3072;
      limit_cfg = 3072;
      period_cfg = 1000;
      zero_cfg = 16'd0;
      clamp_cfg = 1'b1;
      error_count = 0;
      sent_count = 0;
      checked_count = 0;
      idle_cycles = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      recv_hold = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      for (int m = 0; m < 3; m++) begin
         test_random_phase(300, m, 1'b0, m == 2);
         test_random_phase(150, m, 1'b1, 1'b0);
         test_random_phase(160, m, 1'b0, 1'b0);
      end
      drain();

      $display("Covered %0d commands over default, extreme and random register settings,",
               sent_count);
      $display("with sender and receiver stalls and a long output hold-off; %0d checked.",
               checked_count);
      if (error_count == 0) $display("tb_top OK");
      else $display("tb_top NOT OK");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/foc_vm_pkg.sv
rtl/core/foc_vm_sine.sv
rtl/core/foc_vm_divider.sv
rtl/core/foc_voltage_modulator.sv
tb/tb_top.sv
